// ----- sv/ptabmr_pkg.sv -----
// ----------------------------------------------------------------------------
// ptabmr_pkg
// shared types, constants and the arctangent table of the angle binner
// ----------------------------------------------------------------------------
package ptabmr_pkg;

  localparam int MAX_BINS     = 4096;
  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 16;
  localparam int ITER_STEPS   = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
  localparam int BIN_W        = $clog2(MAX_BINS);
  localparam int STEP_W       = $clog2(ITER_STEPS);

  localparam logic [2:0] REG_HEIGHT_MIN  = 3'd0;
  localparam logic [2:0] REG_HEIGHT_MAX  = 3'd1;
  localparam logic [2:0] REG_RANGE_MIN   = 3'd2;
  localparam logic [2:0] REG_RANGE_MAX   = 3'd3;
  localparam logic [2:0] REG_ANGLE_START = 3'd4;
  localparam logic [2:0] REG_BINS_PER_RAD = 3'd5;
  localparam logic [2:0] REG_BIN_COUNT   = 3'd6;
  localparam logic [2:0] REG_EMPTY_VALUE = 3'd7;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // half pi in q16
  localparam logic signed [19:0] HALF_PI = 20'sd102944;

  typedef struct packed {
    logic signed [19:0] height_min;
    logic signed [19:0] height_max;
    logic [15:0]        min_range;
    logic [15:0]        max_range;
    logic signed [18:0] angle_start;
    logic [24:0]        bins_per_radian;
    logic [12:0]        bin_count;
    logic [15:0]        empty_value;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic              mul;
    logic              sum;
    logic              iter_init;
    logic              iter_step;
    logic              bin_mul;
    logic              mem_rd;
    logic              upd;
    logic              rd_out;
    logic              clr;
    logic [BIN_W-1:0]  clr_addr;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic pt_ok;
    logic range_ok;
    logic bin_ok;
    logic out_free;
  } stat_t;

  function automatic logic [15:0] atan_q16(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0:  v = 16'd51472;
      5'd1:  v = 16'd30386;
      5'd2:  v = 16'd16055;
      5'd3:  v = 16'd8150;
      5'd4:  v = 16'd4091;
      5'd5:  v = 16'd2047;
      5'd6:  v = 16'd1024;
      5'd7:  v = 16'd512;
      5'd8:  v = 16'd256;
      5'd9:  v = 16'd128;
      5'd10: v = 16'd64;
      5'd11: v = 16'd32;
      5'd12: v = 16'd16;
      5'd13: v = 16'd8;
      5'd14: v = 16'd4;
      5'd15: v = 16'd2;
      5'd16: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/ptabmr_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptabmr_ctrl
// sequencer: clearing pass, point pipeline steps and bin read
// ----------------------------------------------------------------------------
module ptabmr_ctrl import ptabmr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_fire,
  input  stat_t stat,
  output logic  idle,
  output cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b000000000001,
    S_IDLE   = 12'b000000000010,
    S_MUL    = 12'b000000000100,
    S_SUM    = 12'b000000001000,
    S_RCHK   = 12'b000000010000,
    S_ITER   = 12'b000000100000,
    S_BMUL   = 12'b000001000000,
    S_BCHK   = 12'b000010000000,
    S_UPD    = 12'b000100000000,
    S_RD_REQ = 12'b001000000000,
    S_RD_OUT = 12'b010000000000,
    S_SPARE  = 12'b100000000000
  } state_t;

  state_t            state, state_next;
  logic [BIN_W-1:0]  clr_cnt;
  logic [STEP_W-1:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      step    <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == S_ITER) step <= step + 1'b1;
      else step <= '0;
    end
  end

  assign idle = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.clr_addr = clr_cnt;
    cmd.step     = step;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (clr_cnt == BIN_W'(MAX_BINS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (stat.is_read) state_next = S_RD_REQ;
        else if (!stat.pt_ok) state_next = S_IDLE;
        else begin
          cmd.mul    = 1'b1;
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_RCHK;
      end
      S_RCHK: begin
        if (!stat.range_ok) state_next = S_IDLE;
        else begin
          cmd.iter_init = 1'b1;
          state_next    = S_ITER;
        end
      end
      S_ITER: begin
        cmd.iter_step = 1'b1;
        if (step == STEP_W'(ITER_STEPS - 1)) state_next = S_BMUL;
      end
      S_BMUL: begin
        cmd.bin_mul = 1'b1;
        state_next  = S_BCHK;
      end
      S_BCHK: begin
        if (stat.bin_ok) begin
          cmd.mem_rd = 1'b1;
          state_next = S_UPD;
        end else state_next = S_IDLE;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_IDLE;
      end
      S_RD_REQ: begin
        cmd.mem_rd = 1'b1;
        state_next = S_RD_OUT;
      end
      S_RD_OUT: begin
        if (stat.out_free) begin
          cmd.rd_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- sv/ptabmr_dp.sv -----
// ----------------------------------------------------------------------------
// ptabmr_dp
// datapath: window tests, bit-serial square root, cordic, bin map, bin store
// ----------------------------------------------------------------------------
module ptabmr_dp import ptabmr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               in_op,
  input  logic signed [19:0] in_x,
  input  logic signed [19:0] in_y,
  input  logic signed [19:0] in_z,
  input  logic               in_valid,
  input  logic [11:0]        in_read_bin,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_range,
  output logic               out_hit
);

  // captured item
  logic               op;
  logic signed [19:0] px, py, pz;
  logic               pvalid;
  logic [11:0]        rbin;

  // range path
  logic signed [39:0] x2, y2;
  logic [31:0]        rmin2, rmax2;
  logic [40:0]        sq;

  // square root
  logic [31:0] sq_n;
  logic [15:0] root;
  logic [17:0] rem;
  logic [19:0] rem_sh;
  logic [17:0] trial;
  logic [16:0] root_rnd;

  // cordic
  logic signed [39:0] cx, cy, sx, sy;
  logic signed [19:0] cz, atan_s;
  logic               zero_pt;
  logic signed [39:0] x_sc, y_sc;
  logic signed [20:0] delta;

  // bin map
  logic [44:0]      prod;
  logic             neg;
  logic [12:0]      bin;
  logic [BIN_W-1:0] addr;

  // store
  logic [15:0] rmem [MAX_BINS];
  logic        omem [MAX_BINS];
  logic [15:0] rmem_q;
  logic        omem_q;
  logic        rd_in_range;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= in_op;
      px     <= in_x;
      py     <= in_y;
      pz     <= in_z;
      pvalid <= in_valid;
      rbin   <= in_read_bin;
    end
  end

  assign stat.is_read = (op == OP_READ);
  assign stat.pt_ok   = pvalid && (pz <= cfg.height_max) && (pz >= cfg.height_min);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      x2    <= px * px;
      y2    <= py * py;
      rmin2 <= cfg.min_range * cfg.min_range;
      rmax2 <= cfg.max_range * cfg.max_range;
    end
    if (cmd.sum) sq <= 41'(x2[38:0]) + 41'(y2[38:0]);
  end

  assign stat.range_ok = (sq >= 41'(rmin2)) && (sq <= 41'(rmax2));

  // restoring square root, two radicand bits a step
  assign rem_sh = {rem, sq_n[31:30]};
  assign trial  = {root, 2'b01};

  // cordic vectoring, floor shifts
  assign x_sc   = 40'(px) <<< 16;
  assign y_sc   = 40'(py) <<< 16;
  assign sx     = cx >>> cmd.step;
  assign sy     = cy >>> cmd.step;
  assign atan_s = 20'(atan_q16(5'(cmd.step)));

  always_ff @(posedge clk) begin
    if (cmd.iter_init) begin
      sq_n    <= sq[31:0];
      root    <= '0;
      rem     <= '0;
      zero_pt <= (px == '0) && (py == '0);
      if (x_sc < 0) begin
        if (y_sc >= 0) begin
          cx <= y_sc;
          cy <= -x_sc;
          cz <= HALF_PI;
        end else begin
          cx <= -y_sc;
          cy <= x_sc;
          cz <= -HALF_PI;
        end
      end else begin
        cx <= x_sc;
        cy <= y_sc;
        cz <= '0;
      end
    end else if (cmd.iter_step) begin
      if (32'(cmd.step) < SQRT_STEPS) begin
        sq_n <= sq_n << 2;
        if (rem_sh >= 20'(trial)) begin
          rem  <= 18'(rem_sh - 20'(trial));
          root <= {root[14:0], 1'b1};
        end else begin
          rem  <= rem_sh[17:0];
          root <= {root[14:0], 1'b0};
        end
      end
      if (32'(cmd.step) < CORDIC_STEPS) begin
        if (cy >= 0) begin
          cx <= cx + sy;
          cy <= cy - sx;
          cz <= cz + atan_s;
        end else begin
          cx <= cx - sy;
          cy <= cy + sx;
          cz <= cz - atan_s;
        end
      end
    end
  end

  // nearest integer root, never above the top of the range window
  assign root_rnd = (18'(rem) > 18'(root)) ? 17'(root) + 17'd1 : 17'(root);

  assign delta = (zero_pt ? 21'sd0 : 21'(cz)) - 21'(cfg.angle_start);

  always_ff @(posedge clk) begin
    if (cmd.bin_mul) begin
      prod <= 45'(delta[19:0]) * 45'(cfg.bins_per_radian);
      neg  <= delta[20];
    end
  end

  assign bin         = prod[44:32];
  assign stat.bin_ok = !neg && (bin < cfg.bin_count) && (32'(bin) < MAX_BINS);
  assign rd_in_range = 32'(rbin) < MAX_BINS;
  assign addr        = stat.is_read ? BIN_W'(rbin) : BIN_W'(bin);

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rmem_q <= rmem[addr];
      omem_q <= omem[addr];
    end
    if (cmd.upd && (!omem_q || root_rnd[15:0] < rmem_q)) rmem[addr] <= root_rnd[15:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) omem[cmd.clr_addr] <= 1'b0;
    else if (cmd.upd) omem[addr] <= 1'b1;
    else if (cmd.rd_out && rd_in_range) omem[addr] <= 1'b0;
  end

  // result register
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.rd_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_out) begin
      out_hit   <= rd_in_range && omem_q;
      out_range <= (rd_in_range && omem_q) ? rmem_q : cfg.empty_value;
    end
  end

endmodule

// ----- sv/point_to_angle_bin_min_range.sv -----
// ----------------------------------------------------------------------------
// point_to_angle_bin_min_range
// height/range filtered points binned by bearing, minimum range kept per bin
// ----------------------------------------------------------------------------
// add requests (tuser op 0) carry one point; a valid point inside the height
// and range windows gets its planar range (rounded square root) and bearing
// (iterative cordic) and lowers the stored minimum of its angular bin. read
// requests (tuser op 1) return one bin and clear it; add requests return
// nothing. one request is worked at a time: an add that passes the windows runs
// the 16 shared square root / cordic iterations and ends sooner when it is
// rejected early; a read may also wait on m_tready. after reset a
// clearing pass walks the 4096-entry occupancy memory, one entry a cycle, and
// s_tready stays low until the pass ends; configuration writes are taken at
// any time. write configuration only while no request is in flight.
module point_to_angle_bin_min_range import ptabmr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // point_x, point_y, point_z, point_valid, read_bin
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // bin_range
  output logic        m_tuser,   // bin_hit
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [24:0] cfg_data
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic  idle;
  logic  in_fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.height_min      <= 20'sd0;
      cfg.height_max      <= 20'sd5000;
      cfg.min_range       <= 16'd100;
      cfg.max_range       <= 16'd35000;
      cfg.angle_start     <= -19'sd205887;
      cfg.bins_per_radian <= 25'd22529662;
      cfg.bin_count       <= 13'd2160;
      cfg.empty_value     <= 16'd36000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEIGHT_MIN:   cfg.height_min      <= cfg_data[19:0];
        REG_HEIGHT_MAX:   cfg.height_max      <= cfg_data[19:0];
        REG_RANGE_MIN:    cfg.min_range       <= cfg_data[15:0];
        REG_RANGE_MAX:    cfg.max_range       <= cfg_data[15:0];
        REG_ANGLE_START:  cfg.angle_start     <= cfg_data[18:0];
        REG_BINS_PER_RAD: cfg.bins_per_radian <= cfg_data;
        REG_BIN_COUNT:    cfg.bin_count       <= cfg_data[12:0];
        REG_EMPTY_VALUE:  cfg.empty_value     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // one request at a time, taken only in idle
  assign s_tready = idle;
  assign in_fire  = s_tvalid && s_tready;

  ptabmr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .stat    (stat),
    .idle    (idle),
    .cmd     (cmd)
  );

  ptabmr_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .stat        (stat),
    .in_op       (s_tuser),
    .in_x        (s_tdata[19:0]),
    .in_y        (s_tdata[39:20]),
    .in_z        (s_tdata[59:40]),
    .in_valid    (s_tdata[60]),
    .in_read_bin (s_tdata[72:61]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_range   (m_tdata),
    .out_hit     (m_tuser)
  );

`ifndef SYNTHESIS
  // clearing pass holds off requests right after reset
  a_clear_blocks: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("request taken during clearing pass");

  // a new request never follows in the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready)
    else $error("second request accepted while busy");

  // a result only comes from a read request
  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.rd_out))
    else $error("result without read request");

  // results are issued only into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_out |-> stat.out_free)
    else $error("result overwrote a pending result");
`endif

endmodule
